>>> rtl/core/pipc_pkg.sv
`default_nettype none

package pipc_pkg;

  localparam int COORD_BITS_DEF = 30;
  localparam int OUT_W          = 8;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipc_load_t;

endpackage

`default_nettype wire

>>> rtl/core/pipc_front.sv
`default_nettype none

module pipc_front #(
  parameter int COORD_BITS = pipc_pkg::COORD_BITS_DEF
) (
  input  wire                        clk,
  input  pipc_pkg::pipc_load_t       load,
  input  wire  [COORD_BITS-1:0]      query_x,
  input  wire  [COORD_BITS-1:0]      query_y,
  input  wire  [COORD_BITS-1:0]      query_end_x,
  input  wire  [COORD_BITS-1:0]      query_end_y,
  input  wire  [COORD_BITS-1:0]      edge_start_x,
  input  wire  [COORD_BITS-1:0]      edge_start_y,
  input  wire  [COORD_BITS-1:0]      edge_end_x,
  input  wire  [COORD_BITS-1:0]      edge_end_y,
  output logic [COORD_BITS:0]        vx,
  output logic [COORD_BITS:0]        vy,
  output logic [COORD_BITS:0]        mx,
  output logic [COORD_BITS:0]        my,
  output logic [COORD_BITS-1:0]      ax,
  output logic [COORD_BITS-1:0]      ay,
  output logic [COORD_BITS-1:0]      by,
  output logic [COORD_BITS:0]        dx,
  output logic [COORD_BITS:0]        dy
);
  import pipc_pkg::*;

  localparam int N = COORD_BITS;

  logic [N-1:0] qx1_r, qy1_r, ex1_r, ey1_r, ax1_r, ay1_r, bx1_r, by1_r;

  logic [N:0]   dqx_nxt, dqy_nxt, dx2_nxt, dy2_nxt;
  logic [N:0]   dqx2_r, dqy2_r, dx2_r, dy2_r;
  logic [N-1:0] qx2_r, qy2_r, ax2_r, ay2_r, by2_r;

  logic [N:0]   adjx, adjy, mx_nxt, my_nxt;
  logic [N-1:0] hx, hy;
  logic [N:0]   mx3_r, my3_r, dx3_r, dy3_r;
  logic [N-1:0] qx3_r, qy3_r, ax3_r, ay3_r, by3_r;

  always_ff @(posedge clk) begin
    if (load.s1) begin
      qx1_r <= query_x;
      qy1_r <= query_y;
      ex1_r <= query_end_x;
      ey1_r <= query_end_y;
      ax1_r <= edge_start_x;
      ay1_r <= edge_start_y;
      bx1_r <= edge_end_x;
      by1_r <= edge_end_y;
    end
  end

  assign dqx_nxt = {ex1_r[N-1], ex1_r} - {qx1_r[N-1], qx1_r};
  assign dqy_nxt = {ey1_r[N-1], ey1_r} - {qy1_r[N-1], qy1_r};
  assign dx2_nxt = {bx1_r[N-1], bx1_r} - {ax1_r[N-1], ax1_r};
  assign dy2_nxt = {by1_r[N-1], by1_r} - {ay1_r[N-1], ay1_r};

  always_ff @(posedge clk) begin
    if (load.s2) begin
      dqx2_r <= dqx_nxt;
      dqy2_r <= dqy_nxt;
      dx2_r  <= dx2_nxt;
      dy2_r  <= dy2_nxt;
      qx2_r  <= qx1_r;
      qy2_r  <= qy1_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      by2_r  <= by1_r;
    end
  end

  // halve toward zero: add one before the arithmetic shift when negative
  assign adjx   = dqx2_r + {{N{1'b0}}, dqx2_r[N]};
  assign adjy   = dqy2_r + {{N{1'b0}}, dqy2_r[N]};
  assign hx     = adjx[N:1];
  assign hy     = adjy[N:1];
  assign mx_nxt = {qx2_r[N-1], qx2_r} + {hx[N-1], hx};
  assign my_nxt = {qy2_r[N-1], qy2_r} + {hy[N-1], hy};

  always_ff @(posedge clk) begin
    if (load.s3) begin
      mx3_r <= mx_nxt;
      my3_r <= my_nxt;
      dx3_r <= dx2_r;
      dy3_r <= dy2_r;
      qx3_r <= qx2_r;
      qy3_r <= qy2_r;
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      by3_r <= by2_r;
    end
  end

  assign vx = {qx3_r[N-1], qx3_r};
  assign vy = {qy3_r[N-1], qy3_r};
  assign mx = mx3_r;
  assign my = my3_r;
  assign ax = ax3_r;
  assign ay = ay3_r;
  assign by = by3_r;
  assign dx = dx3_r;
  assign dy = dy3_r;

endmodule

`default_nettype wire

>>> rtl/core/pipc_cross.sv
`default_nettype none

module pipc_cross #(
  parameter int COORD_BITS = pipc_pkg::COORD_BITS_DEF
) (
  input  wire                        clk,
  input  pipc_pkg::pipc_load_t       load,
  input  wire  [COORD_BITS:0]        px,
  input  wire  [COORD_BITS:0]        py,
  input  wire  [COORD_BITS-1:0]      ax,
  input  wire  [COORD_BITS-1:0]      ay,
  input  wire  [COORD_BITS-1:0]      by,
  input  wire  [COORD_BITS:0]        dx,
  input  wire  [COORD_BITS:0]        dy,
  output logic                       toggle
);
  import pipc_pkg::*;

  localparam int N  = COORD_BITS;
  localparam int PW = 2 * COORD_BITS + 3;

  logic [N+1:0]          dtx_nxt, dty_nxt;
  logic                  straddle_nxt;
  logic [N+1:0]          dtx_r, dty_r;
  logic [N:0]            dx4_r, dy4_r;
  logic                  straddle4_r;

  logic signed [PW-1:0]  p_nxt, q_nxt;
  logic signed [PW-1:0]  p_r, q_r;
  logic                  straddle5_r;
  logic                  dy_neg5_r;

  assign dtx_nxt = {px[N], px} - {{2{ax[N-1]}}, ax};
  assign dty_nxt = {py[N], py} - {{2{ay[N-1]}}, ay};
  assign straddle_nxt = ($signed({ay[N-1], ay}) > $signed(py)) !=
                        ($signed({by[N-1], by}) > $signed(py));

  always_ff @(posedge clk) begin
    if (load.s4) begin
      dtx_r       <= dtx_nxt;
      dty_r       <= dty_nxt;
      dx4_r       <= dx;
      dy4_r       <= dy;
      straddle4_r <= straddle_nxt;
    end
  end

  assign p_nxt = $signed(dy4_r) * $signed(dtx_r);
  assign q_nxt = $signed(dx4_r) * $signed(dty_r);

  always_ff @(posedge clk) begin
    if (load.s5) begin
      p_r         <= p_nxt;
      q_r         <= q_nxt;
      straddle5_r <= straddle4_r;
      dy_neg5_r   <= dy4_r[N];
    end
  end

  assign toggle = straddle5_r & ((p_r < q_r) ^ dy_neg5_r);

endmodule

`default_nettype wire

>>> rtl/core/point_in_polygon_crossing.sv
// Crossing-number point-in-polygon test, one polygon edge per transaction.
// Input channel: each transaction carries one edge plus the query wall's start
// and end vertices; in_tlast marks the final edge of a query. The block tests
// the wall's start vertex and its midpoint against every edge.
// Output channel: one transaction per query, sent after the tlast edge, with
// inside_res, vertex_parity and midpoint_parity.
// Throughput: one edge per cycle unless a waiting result stalls the pipeline,
// set by a five-stage pipeline (input register, differences, midpoint,
// cross-term differences, products) feeding the parity toggle registers.
// out_tvalid is registered, set when the tlast edge leaves the products stage.
// Reset (rst_n low, synchronous) clears both parities, all pipeline valids and
// the output valid.
// Stall: while a result waits on out_tready, edges that produce no result keep
// flowing; the pipeline holds only when a tlast edge reaches the parity stage
// and the output register is still full.
`default_nettype none

module point_in_polygon_crossing #(
  parameter int COORD_BITS = pipc_pkg::COORD_BITS_DEF
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        in_tvalid,
  output logic                                       in_tready,
  // query_x, query_y, query_end_x, query_end_y,
  // edge_start_x, edge_start_y, edge_end_x, edge_end_y
  input  wire  [((8*COORD_BITS+7)/8)*8-1:0]          in_tdata,
  input  wire                                        in_tlast,
  output logic                                       out_tvalid,
  input  wire                                        out_tready,
  // inside_res, vertex_parity, midpoint_parity
  output logic [pipc_pkg::OUT_W-1:0]                 out_tdata
);
  import pipc_pkg::*;

  localparam int N = COORD_BITS;

  pipc_load_t   load;
  logic         consume;
  logic         fire;

  logic [5:1]   valid_r;
  logic [5:1]   last_r;

  logic [N:0]   vx, vy, mx, my, dx, dy;
  logic [N-1:0] ax, ay, by;
  logic         tog_v, tog_m;

  logic         vpar_r, mpar_r;
  logic         vpar_nxt, mpar_nxt;
  logic         out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  assign consume = !last_r[5] || !out_valid_r || out_tready;
  assign load.s5 = !valid_r[5] || consume;
  assign load.s4 = !valid_r[4] || load.s5;
  assign load.s3 = !valid_r[3] || load.s4;
  assign load.s2 = !valid_r[2] || load.s3;
  assign load.s1 = !valid_r[1] || load.s2;
  assign in_tready = load.s1;
  assign fire = valid_r[5] && consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (load.s1) valid_r[1] <= in_tvalid;
      if (load.s2) valid_r[2] <= valid_r[1];
      if (load.s3) valid_r[3] <= valid_r[2];
      if (load.s4) valid_r[4] <= valid_r[3];
      if (load.s5) valid_r[5] <= valid_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (load.s1) last_r[1] <= in_tlast;
    if (load.s2) last_r[2] <= last_r[1];
    if (load.s3) last_r[3] <= last_r[2];
    if (load.s4) last_r[4] <= last_r[3];
    if (load.s5) last_r[5] <= last_r[4];
  end

  pipc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .load         (load),
    .query_x      (in_tdata[0*N +: N]),
    .query_y      (in_tdata[1*N +: N]),
    .query_end_x  (in_tdata[2*N +: N]),
    .query_end_y  (in_tdata[3*N +: N]),
    .edge_start_x (in_tdata[4*N +: N]),
    .edge_start_y (in_tdata[5*N +: N]),
    .edge_end_x   (in_tdata[6*N +: N]),
    .edge_end_y   (in_tdata[7*N +: N]),
    .vx           (vx),
    .vy           (vy),
    .mx           (mx),
    .my           (my),
    .ax           (ax),
    .ay           (ay),
    .by           (by),
    .dx           (dx),
    .dy           (dy)
  );

  pipc_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross_vertex (
    .clk    (clk),
    .load   (load),
    .px     (vx),
    .py     (vy),
    .ax     (ax),
    .ay     (ay),
    .by     (by),
    .dx     (dx),
    .dy     (dy),
    .toggle (tog_v)
  );

  pipc_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross_mid (
    .clk    (clk),
    .load   (load),
    .px     (mx),
    .py     (my),
    .ax     (ax),
    .ay     (ay),
    .by     (by),
    .dx     (dx),
    .dy     (dy),
    .toggle (tog_m)
  );

  assign vpar_nxt = vpar_r ^ tog_v;
  assign mpar_nxt = mpar_r ^ tog_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpar_r      <= 1'b0;
      mpar_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        if (last_r[5]) begin
          vpar_r <= 1'b0;
          mpar_r <= 1'b0;
        end else begin
          vpar_r <= vpar_nxt;
          mpar_r <= mpar_nxt;
        end
      end
      if (fire && last_r[5]) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last_r[5]) begin
      out_data_r <= {{(OUT_W-3){1'b0}}, mpar_nxt, vpar_nxt, vpar_nxt | mpar_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> test/point_in_polygon_crossing_check.sv
module point_in_polygon_crossing_check #(
  parameter int CW = pipc_pkg::COORD_BITS_DEF,
  parameter int DW = ((8*CW+7)/8)*8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [DW-1:0]              in_tdata,
  input  logic                       in_tlast,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [pipc_pkg::OUT_W-1:0] out_tdata,
  output int                         mismatches,
  output int                         outstanding,
  output int                         edges_seen,
  output int                         queries_done,
  output int                         inside_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit inside_res;
    bit vertex_parity;
    bit midpoint_parity;
  } verdict_t;

  verdict_t verdicts_due[$];
  bit       vtx_parity;
  bit       mid_parity;

  function automatic longint coord_at(logic [DW-1:0] d, int k);
    logic signed [CW-1:0] v;
    v = d[k*CW +: CW];
    return longint'(v);
  endfunction

  function automatic bit edge_flips_parity(longint px, longint py, longint ax, longint ay,
                                           longint bx, longint by);
    logic signed [127:0] dy_w, dx_w, tx_w, ty_w, lhs, rhs;
    if ((ay > py) == (by > py)) return 1'b0;
    dx_w = 128'(bx - ax);
    dy_w = 128'(by - ay);
    tx_w = 128'(px - ax);
    ty_w = 128'(py - ay);
    lhs = dy_w * tx_w;
    rhs = dx_w * ty_w;
    return (lhs < rhs) != (dy_w < 0);
  endfunction

  always @(posedge clk) begin : watch
    longint   c[8];
    longint   mx;
    longint   my;
    verdict_t want;
    bit [2:0] got;
    bit [2:0] exp_bits;
    string    field_name[3];
    field_name = '{"inside_res", "vertex_parity", "midpoint_parity"};
    if (!rst_n) begin
      vtx_parity = 1'b0;
      mid_parity = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        for (int k = 0; k < 8; k++) c[k] = coord_at(in_tdata, k);
        mx = c[0] + (c[2] - c[0]) / 2;
        my = c[1] + (c[3] - c[1]) / 2;
        vtx_parity ^= edge_flips_parity(c[0], c[1], c[4], c[5], c[6], c[7]);
        mid_parity ^= edge_flips_parity(mx, my, c[4], c[5], c[6], c[7]);
        edges_seen++;
        if (in_tlast) begin
          want.inside_res      = vtx_parity | mid_parity;
          want.vertex_parity   = vtx_parity;
          want.midpoint_parity = mid_parity;
          verdicts_due.push_back(want);
          outstanding++;
          vtx_parity = 1'b0;
          mid_parity = 1'b0;
        end
      end
      if (out_tvalid && out_tready) begin
        queries_done++;
        got = out_tdata[2:0];
        if (verdicts_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %b", $time, got);
        end else begin
          want = verdicts_due.pop_front();
          outstanding--;
          exp_bits = {want.midpoint_parity, want.vertex_parity, want.inside_res};
          for (int f = 0; f < 3; f++) begin
            if (got[f] !== exp_bits[f]) begin
              mismatches++;
              $display("%0t: %s mismatch, expected %b, actual %b", $time, field_name[f],
                       exp_bits[f], got[f]);
            end
          end
          if (got[0]) inside_hits++;
        end
      end
    end
  end

endmodule

>>> test/point_in_polygon_crossing_tb.sv
module point_in_polygon_crossing_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = pipc_pkg::COORD_BITS_DEF;
  localparam int DW         = ((8*CW+7)/8)*8;
  localparam int PHASE_EDGES = 375;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT      = 300000;
  localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

  typedef struct {
    logic signed [CW-1:0] qx, qy, ex, ey, ax, ay, bx, by;
    logic                 last_edge;
  } edge_t;

  logic                       clk;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [DW-1:0]              in_tdata   = '0;
  logic                       in_tlast   = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [pipc_pkg::OUT_W-1:0] out_tdata;

  int mismatches, outstanding, edges_seen, queries_done, inside_hits;
  int send_idle_pct = 0;
  int rx_stall_pct  = 0;
  int edges_sent    = 0;
  int cycles        = 0;

  point_in_polygon_crossing #(.COORD_BITS(CW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  point_in_polygon_crossing_check #(.CW(CW), .DW(DW)) check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .edges_seen  (edges_seen),
    .queries_done(queries_done),
    .inside_hits (inside_hits)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("point_in_polygon_crossing_tb failed");
      $finish;
    end
  end

  // hold off the result side right after reset so the pipeline backs up
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
    forever begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
      @(posedge clk);
    end
  end

  function automatic edge_t mk(logic signed [CW-1:0] qx, logic signed [CW-1:0] qy,
                               logic signed [CW-1:0] ex, logic signed [CW-1:0] ey,
                               logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                               logic signed [CW-1:0] bx, logic signed [CW-1:0] by,
                               logic last_edge);
    edge_t e;
    e.qx = qx; e.qy = qy; e.ex = ex; e.ey = ey;
    e.ax = ax; e.ay = ay; e.bx = bx; e.by = by;
    e.last_edge = last_edge;
    return e;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    int pick;
    if (mode == 3) mode = $urandom_range(2);
    case (mode)
      0: return CW'($urandom);
      1: return CW'(int'($urandom_range(40)) - 20);
      default: begin
        pick = $urandom_range(6);
        case (pick)
          0: return MINC;
          1: return MAXC;
          2: return CW'(MINC + 1);
          3: return CW'(MAXC - 1);
          4: return -1;
          5: return 1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  task automatic send_edge(input edge_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DW'({e.by, e.bx, e.ay, e.ax, e.ey, e.ex, e.qy, e.qx});
    in_tlast  <= e.last_edge;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    edges_sent++;
  endtask

  // closed polygon loop most of the time, loose edges and early tlast otherwise
  task automatic random_query();
    logic signed [CW-1:0] vx[20];
    logic signed [CW-1:0] vy[20];
    edge_t e;
    int    n, mode, sel, j;
    bit    noise;
    sel   = $urandom_range(99);
    mode  = (sel < 40) ? 0 : (sel < 85) ? 1 : (sel < 92) ? 2 : 3;
    n     = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(3, 8);
    noise = ($urandom_range(99) < 12);
    for (int i = 0; i < n; i++) begin
      vx[i] = rand_coord(mode);
      vy[i] = rand_coord(mode);
    end
    e.qx = rand_coord(mode);
    e.qy = rand_coord(mode);
    e.ex = rand_coord(mode);
    e.ey = rand_coord(mode);
    for (int i = 0; i < n; i++) begin
      j = (i + 1) % n;
      if (noise) begin
        e.ax = rand_coord(3); e.ay = rand_coord(3);
        e.bx = rand_coord(3); e.by = rand_coord(3);
        if ($urandom_range(3) == 0) begin
          e.qx = rand_coord(mode); e.qy = rand_coord(mode);
        end
        e.last_edge = (i == n - 1) || ($urandom_range(3) == 0);
      end else begin
        e.ax = vx[i]; e.ay = vy[i];
        e.bx = vx[j]; e.by = vy[j];
        e.last_edge = (i == n - 1);
      end
      send_edge(e);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_edge(mk(MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC, 1'b1));
    send_edge(mk(MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, 1'b1));
    // horizontal edge, then a crossing edge
    send_edge(mk(0, 0, 0, 0, -5, 3, 7, 3, 1'b0));
    send_edge(mk(0, 0, 0, 0, 5, -5, 5, 5, 1'b1));
    // point on the edge: zero cross term, both edge directions
    send_edge(mk(0, 0, 0, 0, 0, -5, 0, 5, 1'b1));
    send_edge(mk(0, 0, 0, 0, 0, 5, 0, -5, 1'b1));
    // vertex outside, midpoint inside
    send_edge(mk(-20, 0, 0, 0, -15, -15, 15, -15, 1'b0));
    send_edge(mk(-20, 0, 0, 0, 15, -15, 15, 15, 1'b0));
    send_edge(mk(-20, 0, 0, 0, 15, 15, -15, 15, 1'b0));
    send_edge(mk(-20, 0, 0, 0, -15, 15, -15, -15, 1'b1));
    // odd negative wall vector: halving truncates toward zero
    send_edge(mk(3, 4, -4, -5, -15, -15, 15, -15, 1'b0));
    send_edge(mk(3, 4, -4, -5, 15, -15, 15, 15, 1'b0));
    send_edge(mk(3, 4, -4, -5, 15, 15, -15, 15, 1'b0));
    send_edge(mk(3, 4, -4, -5, -15, 15, -15, -15, 1'b1));
    // full-range edges, largest products
    send_edge(mk(MINC, 0, MAXC, 1, MAXC, MINC, MAXC, MAXC, 1'b0));
    send_edge(mk(MINC, 0, MAXC, 1, MINC, MAXC, MINC, MINC, 1'b1));
    send_edge(mk(MAXC, MINC, MINC, MAXC, MINC, MAXC, MAXC, CW'(MINC + 1), 1'b1));
    // query y equal to an endpoint y
    send_edge(mk(0, 5, 0, 5, 3, 5, 3, 10, 1'b0));
    send_edge(mk(0, 5, 0, 5, 3, 0, 3, 5, 1'b1));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 70; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin send_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      while (edges_sent < 19 + (ph + 1) * PHASE_EDGES) random_query();
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d edges in %0d queries; %0d queries reported inside",
             edges_seen, queries_done, inside_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("point_in_polygon_crossing_tb passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, outstanding);
      $display("point_in_polygon_crossing_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/pipc_pkg.sv
rtl/core/pipc_front.sv
rtl/core/pipc_cross.sv
rtl/core/point_in_polygon_crossing.sv
test/point_in_polygon_crossing_check.sv
test/point_in_polygon_crossing_tb.sv
